### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL; each reports by $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// Implication after a fixed number of cycles
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("latency check failed");

`endif

### rtl/q15alu_pkg.sv
// ---------------------------------------------------------------------------
// q15alu_pkg
// Types and constants for the Q15 fixed-point arithmetic unit.
// ---------------------------------------------------------------------------
package q15alu_pkg;

	// Number format
	localparam int FRACTION_BITS = 15;
	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;

	// Divider: dividend magnitude needs DATA_W + FRACTION_BITS bits, one bit per stage
	localparam int DVD_W      = DATA_W + FRACTION_BITS;
	localparam int DIV_STAGES = DVD_W;

	// Cycles from accepted start to done strobe
	localparam int LATENCY = DIV_STAGES + 4;

	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
	localparam logic [DATA_W-1:0] INT_MAX    = {1'b0, {(DATA_W - 1){1'b1}}};

	// Operation codes
	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	// Side data carried alongside the divider
	typedef struct packed {
		mode_t             mode;
		logic [DATA_W-1:0] value;
		logic              dz;
		logic              neg;
	} pass_t;

endpackage

### rtl/q15_fixed_point_alu_unit.sv
// ---------------------------------------------------------------------------
// q15_fixed_point_alu_unit
// Pipelined Q15 add / subtract / multiply / divide on 32-bit signed words.
// ---------------------------------------------------------------------------
// A transaction is taken on every clock edge with start high; busy is always
// low, so one operation can enter per cycle. Each transaction produces one
// result, presented for a single cycle with done high, in issue order.
// The divider is a restoring divider with one quotient bit per pipeline
// stage over the 47-bit dividend magnitude. All modes travel the same
// pipeline. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module q15_fixed_point_alu_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     mode,
	input  logic [q15alu_pkg::DATA_W-1:0]  operand_a,
	input  logic [q15alu_pkg::DATA_W-1:0]  operand_b,
	output logic                           done,
	output logic [q15alu_pkg::DATA_W-1:0]  result_value,
	output logic                           divide_by_zero
);
	import q15alu_pkg::*;

	// Stage 1: input registers
	logic                     vld_s1;
	mode_t                    mode_s1;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;

	// Stage 2: add/sub, product, divide set-up
	logic                     vld_s2;
	mode_t                    mode_s2;
	logic [DATA_W-1:0]        value_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] num_s2;
	logic [DATA_W-1:0]        dsr_s2;
	logic                     bneg_s2;
	logic                     dz_s2;

	// Divider array; index 0 is stage 3, index k is divider step k
	logic              vld_sk  [0:DIV_STAGES];
	pass_t             pass_sk [0:DIV_STAGES];
	logic [DVD_W-1:0]  dvd_sk  [0:DIV_STAGES];
	logic [DATA_W-1:0] rem_sk  [0:DIV_STAGES];
	logic [DATA_W-1:0] dsr_sk  [0:DIV_STAGES];

	logic signed [PROD_W-1:0] a_ext;
	logic signed [PROD_W-1:0] b_ext;
	logic signed [PROD_W-1:0] half_ext;
	logic [DATA_W-1:0]        addsub_c;
	logic [PROD_W-1:0]        rnd_c;
	logic [PROD_W-1:0]        mul_shift_c;
	logic [PROD_W-1:0]        num_abs_c;
	logic [DATA_W-1:0]        quo_c;
	logic [DATA_W-1:0]        final_c;

	assign busy = 1'b0;

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_s1 <= mode_t'(mode);
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
	end

	// Stage 2 logic
	assign a_ext    = PROD_W'(a_s1);
	assign b_ext    = PROD_W'(b_s1);
	assign half_ext = PROD_W'(b_s1 >>> 1);

	always_comb begin
		case (mode_s1)
			MODE_ADD: addsub_c = a_s1 + b_s1;
			MODE_SUB: addsub_c = a_s1 - b_s1;
			default:  addsub_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2  <= mode_s1;
		value_s2 <= addsub_c;
		prod_s2  <= a_ext * b_ext;
		num_s2   <= (a_ext <<< FRACTION_BITS) + half_ext;
		dsr_s2   <= b_s1[DATA_W-1] ? DATA_W'(-b_s1) : DATA_W'(b_s1);
		bneg_s2  <= b_s1[DATA_W-1];
		dz_s2    <= (mode_s1 == MODE_DIV) && (b_s1 == '0);
	end

	// Stage 3 logic: multiply rounding, dividend magnitude
	assign rnd_c       = prod_s2 + ROUND_HALF;
	assign mul_shift_c = rnd_c >> FRACTION_BITS;
	assign num_abs_c   = num_s2[PROD_W-1] ? PROD_W'(-num_s2) : PROD_W'(num_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk[0] <= 1'b0;
		end else begin
			vld_sk[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pass_sk[0].mode  <= mode_s2;
		pass_sk[0].value <= (mode_s2 == MODE_MUL) ? mul_shift_c[DATA_W-1:0] : value_s2;
		pass_sk[0].dz    <= dz_s2;
		pass_sk[0].neg   <= num_s2[PROD_W-1] ^ bneg_s2;
		dvd_sk[0]        <= num_abs_c[DVD_W-1:0];
		rem_sk[0]        <= '0;
		dsr_sk[0]        <= dsr_s2;
	end

	// Restoring divider, one quotient bit per stage
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		logic [DATA_W:0] trial;
		logic [DATA_W:0] diff;

		assign trial = {rem_sk[k-1], dvd_sk[k-1][DVD_W-1]};
		assign diff  = trial - {1'b0, dsr_sk[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else begin
				vld_sk[k] <= vld_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			pass_sk[k] <= pass_sk[k-1];
			dsr_sk[k]  <= dsr_sk[k-1];
			if (!diff[DATA_W]) begin
				rem_sk[k] <= diff[DATA_W-1:0];
				dvd_sk[k] <= {dvd_sk[k-1][DVD_W-2:0], 1'b1};
			end else begin
				rem_sk[k] <= trial[DATA_W-1:0];
				dvd_sk[k] <= {dvd_sk[k-1][DVD_W-2:0], 1'b0};
			end
		end
	end

	// Output stage: quotient sign and result select
	assign quo_c = pass_sk[DIV_STAGES].neg ? (~dvd_sk[DIV_STAGES][DATA_W-1:0] + DATA_W'(1))
	                                       : dvd_sk[DIV_STAGES][DATA_W-1:0];

	always_comb begin
		if (pass_sk[DIV_STAGES].mode != MODE_DIV) begin
			final_c = pass_sk[DIV_STAGES].value;
		end else if (pass_sk[DIV_STAGES].dz) begin
			final_c = INT_MAX;
		end else begin
			final_c = quo_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sk[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		result_value   <= final_c;
		divide_by_zero <= pass_sk[DIV_STAGES].dz;
	end

	// Checks
	`ASSERT_DELAY(a_fixed_latency, clk, arst_n, start, LATENCY, done)
	`ASSERT_NEXT(a_no_spurious_done, clk, arst_n, !vld_sk[DIV_STAGES], !done)
	`ASSERT_IMPLIES(a_dz_with_done, clk, arst_n, done && divide_by_zero, result_value == INT_MAX)
	`ASSERT_IMPLIES(a_dz_only_div, clk, arst_n, vld_sk[0] && pass_sk[0].dz, pass_sk[0].mode == MODE_DIV)

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q15 fixed-point arithmetic unit. Directed
// operand extremes for add, subtract, multiply and divide (zero divisor,
// negative divisor, wrap-around) are followed by a long random mix sent in
// bursts with random gaps. Each accepted transaction is predicted in the
// bench and every done strobe is checked, in order, against the oldest
// prediction.
// ---------------------------------------------------------------------------
module tb_top;
	import q15alu_pkg::*;

	localparam int RANDOM_ITEMS   = 1050;
	localparam int WATCHDOG_LIMIT = 600;
	localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              dz;
	} q15_result_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	mode_t             mode   = MODE_ADD;
	logic [DATA_W-1:0] operand_a = '0;
	logic [DATA_W-1:0] operand_b = '0;
	logic              busy;
	logic              done;
	logic [DATA_W-1:0] result_value;
	logic              divide_by_zero;

	q15_result_t q15_results_due[$];
	int          fail_count = 0;
	int          burst_left = 1;
	int          idle_cycles = 0;

	q15_fixed_point_alu_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.done           (done),
		.result_value   (result_value),
		.divide_by_zero (divide_by_zero)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected Q15 result for one operation, low word kept
	function automatic q15_result_t q15_compute(mode_t op, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		longint      sa;
		longint      sb;
		longint      acc;
		q15_result_t r;
		sa = {{32{a[DATA_W-1]}}, a};
		sb = {{32{b[DATA_W-1]}}, b};
		r.dz = 1'b0;
		case (op)
			MODE_ADD: r.value = a + b;
			MODE_SUB: r.value = a - b;
			MODE_MUL: begin
				acc = sa * sb + (longint'(1) <<< (FRACTION_BITS - 1));
				acc = acc >>> FRACTION_BITS;
				r.value = acc[DATA_W-1:0];
			end
			default: begin
				if (b == '0) begin
					r.value = INT_MAX;
					r.dz = 1'b1;
				end else begin
					// rounding term is floor(b/2), negative for a negative divisor
					acc = (sa <<< FRACTION_BITS) + (sb >>> 1);
					acc = acc / sb;
					r.value = acc[DATA_W-1:0];
				end
			end
		endcase
		return r;
	endfunction

	// Record accepted transactions and check results in issue order
	always @(posedge clk) begin
		q15_result_t want;
		if (arst_n) begin
			if (start && !busy)
				q15_results_due.push_back(q15_compute(mode, operand_a, operand_b));
			if (done) begin
				if (q15_results_due.size() == 0) begin
					$error("result with no transaction outstanding: result_value=%h",
						result_value);
					fail_count++;
				end else begin
					want = q15_results_due.pop_front();
					if (result_value !== want.value) begin
						$error("result_value mismatch: expected %h, actual %h",
							want.value, result_value);
						fail_count++;
					end
					if (divide_by_zero !== want.dz) begin
						$error("divide_by_zero mismatch: expected %b, actual %b",
							want.dz, divide_by_zero);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: too long without a transaction taken or a result returned
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Send one operation; gaps fall between bursts of random length
	task automatic send_op(input mode_t op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		start     <= 1'b1;
		mode      <= op;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (busy);
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(4, 12)) @(posedge clk);
			else
				repeat ($urandom_range(1, 3)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// Operand drawn from a mix of corner values, small Q15 numbers and full range
	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: return INT_MIN;
					1: return INT_MAX;
					2: return '0;
					3: return '1;
					4: return DATA_W'(1);
					default: return DATA_W'(1) << FRACTION_BITS;
				endcase
			end
			1, 2: return DATA_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
			3: return DATA_W'($urandom_range(0, 255)) - 32'd128;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_add_sub_extremes();
		send_op(MODE_ADD, 32'h0000_8000, 32'h0000_4000);
		send_op(MODE_ADD, INT_MAX, DATA_W'(1));
		send_op(MODE_ADD, INT_MIN, INT_MIN);
		send_op(MODE_SUB, INT_MIN, DATA_W'(1));
		send_op(MODE_SUB, '0, INT_MIN);
		send_op(MODE_SUB, '1, INT_MAX);
	endtask

	task automatic test_multiply_rounding();
		send_op(MODE_MUL, INT_MAX, INT_MAX);
		send_op(MODE_MUL, INT_MIN, INT_MIN);
		send_op(MODE_MUL, INT_MIN, INT_MAX);
		// half an LSB rounds up, just under rounds down, negative side too
		send_op(MODE_MUL, DATA_W'(1), 32'h0000_4000);
		send_op(MODE_MUL, DATA_W'(1), 32'h0000_3FFF);
		send_op(MODE_MUL, '1, 32'h0000_4001);
		send_op(MODE_MUL, 32'h0000_8000, '1);
	endtask

	task automatic test_divide_cases();
		// zero divisor
		send_op(MODE_DIV, '0, '0);
		send_op(MODE_DIV, INT_MIN, '0);
		// negative divisor, floor(b/2) rounding
		send_op(MODE_DIV, 32'h0000_8000, 32'hFFFF_FFFD);
		send_op(MODE_DIV, INT_MIN, '1);
		send_op(MODE_DIV, INT_MAX, DATA_W'(1));
		send_op(MODE_DIV, INT_MIN, INT_MIN);
		send_op(MODE_DIV, INT_MAX, INT_MIN);
		send_op(MODE_DIV, '1, INT_MAX);
		send_op(MODE_DIV, 32'h0001_8000, 32'h0000_8000);
	endtask

	task automatic test_random_operations();
		mode_t             op;
		logic [DATA_W-1:0] b;
		repeat (RANDOM_ITEMS) begin
			op = mode_t'($urandom_range(0, 3));
			b  = pick_operand();
			if (op == MODE_DIV && $urandom_range(0, 11) == 0)
				b = '0;
			send_op(op, pick_operand(), b);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub_extremes();
		test_multiply_rounding();
		test_divide_cases();
		test_random_operations();
		start <= 1'b0;

		// drain: every result in, then room for any stray strobe
		while (q15_results_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
